### hw/rtl/modexp_pkg.sv
// Shared constants for the modular exponentiation block.
package modexp_pkg;

    // Default operand width for the data channels and the modulus register
    localparam int unsigned MODEXP_WIDTH = 32;

endpackage

### hw/rtl/modexp_req_if.sv
// Request channel of the modular exponentiation block: base and exponent.
interface modexp_req_if #(
    parameter int unsigned WIDTH = modexp_pkg::MODEXP_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

### hw/rtl/modexp_rsp_if.sv
// Response channel of the modular exponentiation block: the reduced power.
interface modexp_rsp_if #(
    parameter int unsigned WIDTH = modexp_pkg::MODEXP_WIDTH
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface

### hw/rtl/modular_exponentiation.sv
// Modular exponentiation: base ** exponent mod modulus, square and multiply.
//
// Usage
//   Write the modulus through i_cfg_we / i_cfg_wdata while the block is idle.
//   Present base and exponent on i_req; a transfer takes place when valid and
//   ready are both high. The result appears on o_rsp and is held until its
//   transfer completes.
// Operation
//   The block works on one request at a time and drops i_req.ready until the
//   result has been computed. All arithmetic runs on one modular adder pair
//   that performs one shift-and-add step per cycle. The base is first reduced
//   modulo the modulus. Each exponent bit then costs a decision step, a
//   multiply when the bit is set and a squaring; the squaring after the last
//   set bit is skipped and scanning stops there. The next request is taken
//   once the result has moved to the output register.
//   A modulus of 0 or 1 gives a result of 0 and skips the arithmetic.
// Reset and stalls
//   Reset empties the output register, returns to idle and sets the modulus
//   to 1. A finished result waits in the output register while o_rsp is
//   stalled; a new request is taken meanwhile, and its result is held back
//   until the output register is free.
module modular_exponentiation #(
    parameter int unsigned WIDTH = modexp_pkg::MODEXP_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [WIDTH-1:0] i_cfg_wdata,
    modexp_req_if.sink       i_req,
    modexp_rsp_if.source     o_rsp
);

    localparam int unsigned CNT_W = $clog2(WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_BIT,
        S_MUL,
        S_DONE
    } t_state;

    t_state           r_state,     n_state;
    logic [WIDTH-1:0] r_modulus,   n_modulus;
    logic [WIDTH-1:0] r_base,      n_base;
    logic [WIDTH-1:0] r_exp,       n_exp;
    logic [WIDTH-1:0] r_res,       n_res;
    logic [WIDTH-1:0] r_acc,       n_acc;
    logic [WIDTH-1:0] r_addend,    n_addend;
    logic [WIDTH-1:0] r_mplier,    n_mplier;
    logic [CNT_W-1:0] r_cnt,       n_cnt;
    logic             r_sq,        n_sq;
    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_power_mod, n_power_mod;

    logic [WIDTH-1:0] add_acc;
    logic [WIDTH-1:0] add_dbl;
    logic [WIDTH-1:0] acc_step;
    logic             dbl_cin;
    logic             last_step;

    // (x + y + cin) mod m, valid for x < m, y < m
    function automatic logic [WIDTH-1:0] mod_add(
        input logic [WIDTH-1:0] x,
        input logic [WIDTH-1:0] y,
        input logic             cin,
        input logic [WIDTH-1:0] m
    );
        logic [WIDTH:0] sum;
        logic [WIDTH:0] diff;
        sum  = {1'b0, x} + {1'b0, y} + {{WIDTH{1'b0}}, cin};
        diff = sum - {1'b0, m};
        if (sum >= {1'b0, m}) begin
            return diff[WIDTH-1:0];
        end
        return sum[WIDTH-1:0];
    endfunction

    // Shared unit: accumulate and double; doubling shifts in a base bit on reduction
    assign dbl_cin   = (r_state == S_REDUCE) ? r_mplier[WIDTH-1] : 1'b0;
    assign add_acc   = mod_add(r_acc, r_addend, 1'b0, r_modulus);
    assign add_dbl   = mod_add(r_addend, r_addend, dbl_cin, r_modulus);
    assign acc_step  = r_mplier[0] ? add_acc : r_acc;
    assign last_step = (r_cnt == CNT_W'(WIDTH - 1));

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.power_mod = r_power_mod;

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_modulus   = i_cfg_we ? i_cfg_wdata : r_modulus;
        n_base      = r_base;
        n_exp       = r_exp;
        n_res       = r_res;
        n_acc       = r_acc;
        n_addend    = r_addend;
        n_mplier    = r_mplier;
        n_cnt       = r_cnt;
        n_sq        = r_sq;
        n_out_valid = r_out_valid;
        n_power_mod = r_power_mod;

        // drop the result once its transfer completes
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_exp    = i_req.exponent;
                    n_mplier = i_req.base;
                    n_addend = '0;
                    n_cnt    = '0;
                    if (r_modulus <= WIDTH'(1)) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_res   = WIDTH'(1);
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                // restoring remainder, one base bit per cycle from the top
                n_addend = add_dbl;
                n_mplier = r_mplier << 1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (last_step) begin
                    n_base  = add_dbl;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                n_acc = '0;
                n_cnt = '0;
                if (r_exp == '0) begin
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    n_addend = r_res;
                    n_mplier = r_base;
                    n_sq     = 1'b0;
                    n_state  = S_MUL;
                end else begin
                    n_addend = r_base;
                    n_mplier = r_base;
                    n_sq     = 1'b1;
                    n_state  = S_MUL;
                end
            end
            S_MUL: begin
                // right-to-left shift-and-add modular product
                n_acc    = acc_step;
                n_addend = add_dbl;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt + CNT_W'(1);
                if (last_step) begin
                    n_acc = '0;
                    n_cnt = '0;
                    if (!r_sq) begin
                        n_res = acc_step;
                        if (r_exp[WIDTH-1:1] == '0) begin
                            n_state = S_DONE;
                        end else begin
                            n_addend = r_base;
                            n_mplier = r_base;
                            n_sq     = 1'b1;
                        end
                    end else begin
                        n_base  = acc_step;
                        n_exp   = r_exp >> 1;
                        n_state = S_BIT;
                    end
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_power_mod = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, datapath and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_modulus   <= WIDTH'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_modulus   <= n_modulus;
        end
        r_base      <= n_base;
        r_exp       <= n_exp;
        r_res       <= n_res;
        r_acc       <= n_acc;
        r_addend    <= n_addend;
        r_mplier    <= n_mplier;
        r_cnt       <= n_cnt;
        r_sq        <= n_sq;
        r_power_mod <= n_power_mod;
    end

    // Requests are taken only while no operation is in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready)
        else $error("request ready while an operation is in flight");

    // Operands of the modular adder stay reduced
    a_addend_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_REDUCE) || (r_state == S_MUL)) |-> (r_addend < r_modulus))
        else $error("addend not reduced below the modulus");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_acc < r_modulus))
        else $error("accumulator not reduced below the modulus");

    // A trivial modulus yields zero straight away
    a_trivial_modulus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (r_modulus <= WIDTH'(1)))
        |=> ((r_state == S_DONE) && (r_res == '0)))
        else $error("trivial modulus did not give zero");

    // A finished result lands in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_valid || o_rsp.ready))
        |=> (r_out_valid && (r_power_mod == $past(r_res))))
        else $error("finished result not loaded into the output register");

endmodule
